// ===== rtl/core/rsh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsh_pkg
// Shared constants, codes and types of the ranger sensor hub.
// ----------------------------------------------------------------------------
package rsh_pkg;

    // Sizes of the hub.
    localparam int NUM_SENSORS  = 6;
    localparam int NUM_BUTTONS  = 4;
    localparam int SLOT_W       = $clog2(NUM_SENSORS);
    localparam int FIRST_ANALOG = 2;
    localparam int BTN_IDX_W    = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // Field widths of the beats.
    localparam int ID_W     = 11;
    localparam int WORD_W   = 16;
    localparam int BYTES_W  = 2;
    localparam int OPCODE_W = 2;

    // Input tdata layout, lowest field first.
    localparam int IN_CH_LSB   = 0;
    localparam int IN_RISE_LSB = 1;
    localparam int IN_TS_LSB   = 2;
    localparam int IN_PINS_LSB = IN_TS_LSB + WORD_W;
    localparam int IN_HI_LSB   = IN_PINS_LSB + NUM_BUTTONS;
    localparam int IN_LO_LSB   = IN_HI_LSB + 8;
    localparam int IN_CID_LSB  = IN_LO_LSB + 8;
    localparam int IN_CW_LSB   = IN_CID_LSB + ID_W;
    localparam int IN_USED_W   = IN_CW_LSB + WORD_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest field first.
    localparam int OUT_USED_W  = ID_W + WORD_W + BYTES_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Message identifiers and command codes.
    localparam logic [ID_W-1:0] ID_RANGER_REPORT = 11'd352;
    localparam logic [ID_W-1:0] ID_BUTTON_REPORT = 11'd272;
    localparam logic [ID_W-1:0] CMD_REQUEST      = 11'd320;
    localparam logic [ID_W-1:0] CMD_THRESHOLD    = 11'd328;
    localparam logic [ID_W-1:0] CMD_MUTE         = 11'd336;
    localparam logic [ID_W-1:0] CMD_UNMUTE       = 11'd344;
    localparam logic [15:0]     CMD_CODE_MASK    = 16'hFFF8;
    localparam logic [7:0]      SLOT_MASK        = 8'h07;

    localparam logic [BYTES_W-1:0] BYTES_NONE = 2'd0;
    localparam logic [BYTES_W-1:0] BYTES_WORD = 2'd2;

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OPC_ECHO = 2'd0;
    localparam logic [OPCODE_W-1:0] OPC_TICK = 2'd1;
    localparam logic [OPCODE_W-1:0] OPC_CMD  = 2'd2;

    // Table operation carried by an item into the update stage.
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_ECHO    = 3'd1,
        OP_TICK    = 3'd2,
        OP_REQUEST = 3'd3,
        OP_THRESH  = 3'd4,
        OP_MUTE    = 3'd5,
        OP_UNMUTE  = 3'd6
    } op_t;

    // One entry of the sensor table.
    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] threshold;
        logic              unmuted;
        logic              below;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Table read request issued at acceptance.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } rd_req_t;

    // Decoded item handed from the front stage to the update stage.
    typedef struct packed {
        op_t                    op;
        logic [SLOT_W-1:0]      addr;
        logic [WORD_W-1:0]      word;
        logic [NUM_BUTTONS-1:0] btn_mask;
        logic [NUM_BUTTONS-1:0] btn_pressed;
    } item_t;

    // Report job handed from the update stage to the emitter.
    typedef struct packed {
        logic [NUM_BUTTONS-1:0] btn_mask;
        logic [NUM_BUTTONS-1:0] btn_pressed;
        logic                   rpt_valid;
        logic [ID_W-1:0]        rpt_id;
        logic [WORD_W-1:0]      rpt_word;
    } job_t;

endpackage
`default_nettype wire

// ===== rtl/core/ranger_sensor_hub_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ranger_sensor_hub_top
// Sensor hub: sonar echo timing, button and analog tick handling and command
// decoding around a six-entry sensor table RAM.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tuser opcode; tdata echo, tick and command fields
//   m_axis    out        tdata report id, word, byte count; tlast end of run
//
// An item is decoded and its table read issued in the cycle it is accepted,
// is read, modified and written back in the update stage, and its reports
// are taken by the emitter, which sends them through the output register.
// Items that cause at most one report stream at one per cycle while m_axis
// is ready; a tick with k reports holds the emitter until all k are sent.
// Reset clears all control state; the table reads as zero through per-entry
// valid bits, so no clearing pass is needed. A stall on m_axis fills the
// output register, the emitter job and the update stage, then drops tready.
// ----------------------------------------------------------------------------
module ranger_sensor_hub_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    // tdata from bit 0: sonar_channel, rising_edge, timestamp, button_pins,
    // adc_high_byte, adc_low_byte, command_id, command_word, zero fill.
    input  wire logic [rsh_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: opcode.
    input  wire logic [rsh_pkg::OPCODE_W-1:0]    s_axis_tuser,
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata from bit 0: message_id, payload_word, payload_bytes, zero fill.
    output      logic [rsh_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output      logic                            m_axis_tlast
);
    import rsh_pkg::*;

    rd_req_t rd_req;
    logic    s1_valid;
    item_t   s1_item;
    logic    s1_adv;
    logic    job_ready;
    logic    job_load;
    job_t    job;

    rsh_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s1_adv        (s1_adv),
        .rd_req        (rd_req),
        .s1_valid      (s1_valid),
        .s1_item       (s1_item)
    );

    rsh_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_req    (rd_req),
        .s1_valid  (s1_valid),
        .s1_item   (s1_item),
        .job_ready (job_ready),
        .s1_adv    (s1_adv),
        .job_load  (job_load),
        .job       (job)
    );

    rsh_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_load      (job_load),
        .job_in        (job),
        .job_ready     (job_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== rtl/core/rsh_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsh_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// A read and a write of the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module rsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rsh_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsh_front
// Accepts input beats, keeps the small per-event state (echo start times,
// button flags, armed sonar, analog cursor), decodes the item, issues the
// sensor table read and holds the item for the update stage.
// ----------------------------------------------------------------------------
module rsh_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    input  wire logic [rsh_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic [rsh_pkg::OPCODE_W-1:0]     s_axis_tuser,
    input  wire logic                             s1_adv,
    output      rsh_pkg::rd_req_t                 rd_req,
    output      logic                             s1_valid,
    output      rsh_pkg::item_t                   s1_item
);
    import rsh_pkg::*;

    logic                   accept;
    logic                   sonar_ch;
    logic                   rising;
    logic [WORD_W-1:0]      ts;
    logic [NUM_BUTTONS-1:0] pins;
    logic [7:0]             adc_hi;
    logic [7:0]             adc_lo;
    logic [ID_W-1:0]        cmd_id;
    logic [WORD_W-1:0]      cmd_word;
    logic [2:0]             cmd_slot;
    logic [ID_W-1:0]        cmd_code;

    logic [WORD_W-1:0]      echo_start_reg [2];
    logic [WORD_W-1:0]      echo_start_next [2];
    logic [NUM_BUTTONS-1:0] pressed_reg;
    logic [NUM_BUTTONS-1:0] pressed_next;
    logic                   armed_reg;
    logic                   armed_next;
    logic [SLOT_W-1:0]      cursor_reg;
    logic [SLOT_W-1:0]      cursor_next;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    item_t                  s1_item_reg;
    item_t                  item_d;

    // Unpack the input beat.
    assign sonar_ch = s_axis_tdata[IN_CH_LSB];
    assign rising   = s_axis_tdata[IN_RISE_LSB];
    assign ts       = s_axis_tdata[IN_TS_LSB +: WORD_W];
    assign pins     = s_axis_tdata[IN_PINS_LSB +: NUM_BUTTONS];
    assign adc_hi   = s_axis_tdata[IN_HI_LSB +: 8];
    assign adc_lo   = s_axis_tdata[IN_LO_LSB +: 8];
    assign cmd_id   = s_axis_tdata[IN_CID_LSB +: ID_W];
    assign cmd_word = s_axis_tdata[IN_CW_LSB +: WORD_W];
    assign cmd_slot = cmd_id[2:0] & SLOT_MASK[2:0];
    assign cmd_code = cmd_id & CMD_CODE_MASK[ID_W-1:0];

    // The front stage takes a beat when it holds no item or the held item moves on.
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Decode the beat and work out the small state updates.
    always_comb
    begin
        item_d             = '0;
        item_d.op          = OP_NONE;
        echo_start_next[0] = echo_start_reg[0];
        echo_start_next[1] = echo_start_reg[1];
        pressed_next       = pressed_reg;
        armed_next         = armed_reg;
        cursor_next        = cursor_reg;

        case (s_axis_tuser)
            OPC_ECHO:
            begin
                if (sonar_ch == armed_reg)
                begin
                    if (rising)
                    begin
                        echo_start_next[sonar_ch] = ts;
                    end
                    else
                    begin
                        item_d.op   = OP_ECHO;
                        item_d.addr = SLOT_W'(sonar_ch);
                        item_d.word = ts - echo_start_reg[sonar_ch];
                    end
                end
            end
            OPC_TICK:
            begin
                // A button reports when its pin level equals its pressed flag.
                for (int i = 0; i < NUM_BUTTONS; i++)
                begin
                    if (pins[i] == pressed_reg[i])
                    begin
                        item_d.btn_mask[i] = 1'b1;
                        pressed_next[i]    = !pins[i];
                    end
                end
                item_d.btn_pressed = ~pins;
                item_d.op          = OP_TICK;
                item_d.addr        = cursor_reg;
                item_d.word        = {6'd0, adc_hi, adc_lo[7:6]};
                armed_next         = !armed_reg;
                if (cursor_reg == SLOT_W'(NUM_SENSORS - 1))
                begin
                    cursor_next = SLOT_W'(FIRST_ANALOG);
                end
                else
                begin
                    cursor_next = cursor_reg + 1'b1;
                end
            end
            OPC_CMD:
            begin
                if ({1'b0, cmd_slot} < 4'(NUM_SENSORS))
                begin
                    item_d.addr = cmd_slot[SLOT_W-1:0];
                    item_d.word = cmd_word;
                    unique case (cmd_code)
                        CMD_REQUEST:   item_d.op = OP_REQUEST;
                        CMD_THRESHOLD: item_d.op = OP_THRESH;
                        CMD_MUTE:      item_d.op = OP_MUTE;
                        CMD_UNMUTE:    item_d.op = OP_UNMUTE;
                        default:       item_d.op = OP_NONE;
                    endcase
                end
            end
            default:
            begin
                item_d.op = OP_NONE;
            end
        endcase
    end

    // Table read for the accepted item; data is ready in the update stage.
    assign rd_req.en   = accept;
    assign rd_req.addr = item_d.addr;

    // Hold flag of the update stage.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_start_reg[0] <= '0;
            echo_start_reg[1] <= '0;
            pressed_reg       <= '0;
            armed_reg         <= 1'b0;
            cursor_reg        <= SLOT_W'(FIRST_ANALOG);
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                echo_start_reg[0] <= echo_start_next[0];
                echo_start_reg[1] <= echo_start_next[1];
                pressed_reg       <= pressed_next;
                armed_reg         <= armed_next;
                cursor_reg        <= cursor_next;
            end
        end
    end

    // Item payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item_d;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

endmodule
`default_nettype wire

// ===== rtl/core/rsh_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsh_update
// Owns the sensor table RAM. Reads the entry of the held item, forwards the
// most recent write over stale read data, modifies the entry, writes it back
// and builds the report job for the emitter.
// ----------------------------------------------------------------------------
module rsh_update (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rsh_pkg::rd_req_t rd_req,
    input  wire logic             s1_valid,
    input  wire rsh_pkg::item_t   s1_item,
    input  wire logic             job_ready,
    output      logic             s1_adv,
    output      logic             job_load,
    output      rsh_pkg::job_t    job
);
    import rsh_pkg::*;

    logic [ENTRY_W-1:0]     rd_data;
    entry_t                 cur;
    entry_t                 upd;
    logic                   wr_en;
    logic                   below;
    logic                   changed;
    logic                   has_job;

    logic [NUM_SENSORS-1:0] valid_reg;
    logic                   fwd_valid_reg;
    logic [SLOT_W-1:0]      fwd_addr_reg;
    entry_t                 fwd_data_reg;

    rsh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SENSORS)
    ) u_table (
        .clk     (clk),
        .wr_en   (s1_adv && wr_en),
        .wr_addr (s1_item.addr),
        .wr_data (upd),
        .rd_en   (rd_req.en),
        .rd_addr (rd_req.addr),
        .rd_data (rd_data)
    );

    // Current entry: the last write wins, an unwritten entry reads as zero.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_item.addr))
        begin
            cur = fwd_data_reg;
        end
        else if (valid_reg[s1_item.addr])
        begin
            cur = entry_t'(rd_data);
        end
        else
        begin
            cur = '0;
        end
    end

    // Modify the entry and build the reports of this item.
    always_comb
    begin
        upd          = cur;
        wr_en        = 1'b0;
        below        = 1'b0;
        changed      = 1'b0;
        job          = '0;
        job.rpt_word = cur.value;

        case (s1_item.op)
            OP_ECHO:
            begin
                below         = s1_item.word < cur.threshold;
                changed       = below != cur.below;
                upd.value     = s1_item.word;
                upd.below     = below;
                wr_en         = 1'b1;
                job.rpt_valid = cur.unmuted || changed;
                job.rpt_id    = ID_RANGER_REPORT
                              | {6'd0, below, changed, 3'(s1_item.addr)};
                job.rpt_word  = s1_item.word;
            end
            OP_TICK:
            begin
                upd.value       = s1_item.word;
                wr_en           = 1'b1;
                job.btn_mask    = s1_item.btn_mask;
                job.btn_pressed = s1_item.btn_pressed;
                job.rpt_valid   = cur.unmuted;
                job.rpt_id      = ID_RANGER_REPORT | {8'd0, 3'(s1_item.addr)};
                job.rpt_word    = s1_item.word;
            end
            OP_REQUEST:
            begin
                below         = cur.value < cur.threshold;
                job.rpt_valid = 1'b1;
                job.rpt_id    = ID_RANGER_REPORT | {6'd0, below, 1'b0, 3'(s1_item.addr)};
            end
            OP_THRESH:
            begin
                upd.threshold = s1_item.word;
                wr_en         = 1'b1;
            end
            OP_MUTE:
            begin
                upd.unmuted = 1'b0;
                wr_en       = 1'b1;
            end
            OP_UNMUTE:
            begin
                upd.unmuted = 1'b1;
                wr_en       = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // The item leaves once its reports, if any, are taken by the emitter.
    assign has_job  = job.rpt_valid || (|job.btn_mask);
    assign s1_adv   = s1_valid && (!has_job || job_ready);
    assign job_load = s1_adv && has_job;

    // Valid bits and the forwarding copy of the last write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (s1_adv && wr_en)
        begin
            valid_reg[s1_item.addr] <= 1'b1;
            fwd_valid_reg           <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && wr_en)
        begin
            fwd_addr_reg <= s1_item.addr;
            fwd_data_reg <= upd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rsh_emitter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsh_emitter
// Holds one report job and sends its reports one beat per cycle while m_axis
// is ready, through the output register: button reports in increasing button
// order, then the ranger report. The final beat of a job carries tlast.
// ----------------------------------------------------------------------------
module rsh_emitter (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            job_load,
    input  wire rsh_pkg::job_t                   job_in,
    output      logic                            job_ready,
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output      logic [rsh_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // id, word, bytes
    output      logic                            m_axis_tlast
);
    import rsh_pkg::*;

    job_t                   job_reg;
    job_t                   job_next;
    logic                   busy;
    logic                   out_ready;
    logic                   fire;
    logic                   last;
    logic [BTN_IDX_W-1:0]   sel;
    logic [NUM_BUTTONS-1:0] sel_hot;
    logic [ID_W-1:0]        beat_id;
    logic [WORD_W-1:0]      beat_word;
    logic [BYTES_W-1:0]     beat_bytes;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic                   m_last_reg;
    logic [ID_W-1:0]        m_id_reg;
    logic [WORD_W-1:0]      m_word_reg;
    logic [BYTES_W-1:0]     m_bytes_reg;

    assign busy      = job_reg.rpt_valid || (|job_reg.btn_mask);
    assign out_ready = !m_valid_reg || m_axis_tready;
    assign fire      = busy && out_ready;

    // Lowest pending button.
    always_comb
    begin
        sel     = '0;
        sel_hot = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--)
        begin
            if (job_reg.btn_mask[i])
            begin
                sel = BTN_IDX_W'(i);
            end
        end
        sel_hot[sel] = |job_reg.btn_mask;
    end

    // Beat selection: a button report first, else the ranger report.
    always_comb
    begin
        if (|job_reg.btn_mask)
        begin
            beat_id    = ID_BUTTON_REPORT | {7'd0, job_reg.btn_pressed[sel], 3'(sel)};
            beat_word  = '0;
            beat_bytes = BYTES_NONE;
            last       = ((job_reg.btn_mask & ~sel_hot) == '0) && !job_reg.rpt_valid;
        end
        else
        begin
            beat_id    = job_reg.rpt_id;
            beat_word  = job_reg.rpt_word;
            beat_bytes = BYTES_WORD;
            last       = 1'b1;
        end
    end

    assign job_ready = !busy || (fire && last);

    // Job bookkeeping: a new job replaces a finished one.
    always_comb
    begin
        job_next = job_reg;
        if (job_load)
        begin
            job_next = job_in;
        end
        else if (fire)
        begin
            if (|job_reg.btn_mask)
            begin
                job_next.btn_mask = job_reg.btn_mask & ~sel_hot;
            end
            else
            begin
                job_next.rpt_valid = 1'b0;
            end
        end
    end

    // Output register valid.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_ready)
        begin
            m_valid_next = fire;
        end
    end

    // Held job and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            job_reg     <= job_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Beat payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            m_id_reg    <= beat_id;
            m_word_reg  <= beat_word;
            m_bytes_reg <= beat_bytes;
            m_last_reg  <= last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({m_bytes_reg, m_word_reg, m_id_reg});

endmodule
`default_nettype wire
